// File: rtl/sct_pkg.sv
// shared types and constants of the shell command tokenizer
`timescale 1ns / 1ps

package sct_pkg;

    // result kinds
    localparam logic [3:0] K_WCHAR = 4'd0;
    localparam logic [3:0] K_WEND  = 4'd1;
    localparam logic [3:0] K_IODIG = 4'd2;
    localparam logic [3:0] K_IOEND = 4'd3;
    localparam logic [3:0] K_PIPE  = 4'd4;
    localparam logic [3:0] K_BG    = 4'd5;
    localparam logic [3:0] K_SEMI  = 4'd6;
    localparam logic [3:0] K_RIN   = 4'd7;
    localparam logic [3:0] K_ROUT  = 4'd8;
    localparam logic [3:0] K_RAPP  = 4'd9;
    localparam logic [3:0] K_END   = 4'd10;
    localparam logic [3:0] K_ERR   = 4'd11;

    // characters the lexer reacts to
    localparam logic [7:0] C_PIPE = 8'h7C;
    localparam logic [7:0] C_AMP  = 8'h26;
    localparam logic [7:0] C_SEMI = 8'h3B;
    localparam logic [7:0] C_LT   = 8'h3C;
    localparam logic [7:0] C_GT   = 8'h3E;
    localparam logic [7:0] C_SQ   = 8'h27;
    localparam logic [7:0] C_DQ   = 8'h22;
    localparam logic [7:0] C_BS   = 8'h5C;
    localparam logic [7:0] C_HASH = 8'h23;
    localparam logic [7:0] C_NL   = 8'h0A;
    localparam logic [7:0] C_SP   = 8'h20;
    localparam logic [7:0] C_TAB  = 8'h09;
    localparam logic [7:0] C_VT   = 8'h0B;
    localparam logic [7:0] C_FF   = 8'h0C;
    localparam logic [7:0] C_CR   = 8'h0D;
    localparam logic [7:0] C_ZERO = 8'h30;
    localparam logic [7:0] C_NINE = 8'h39;
    localparam logic [3:0] DIGIT_HI = 4'h3;

    // what the decoder wants done after its step
    typedef enum logic [1:0] {
        ACT_DONE,
        ACT_REDO,
        ACT_REPLAY_WORD,
        ACT_REPLAY_IO
    } act_t;

    // source of a pushed result
    typedef enum logic [1:0] {
        SRC_DECODE,
        SRC_WDIGIT,
        SRC_IODIGIT,
        SRC_IOEND
    } src_t;

    typedef struct packed {
        logic [3:0] kind;
        logic [7:0] ch;
        logic       lit;
        logic       hl;
    } res_t;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic apply;
        logic push;
        logic push_final;
        logic flush;
        src_t src;
        logic rep_adv;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic hold_v;
        logic out_free;
        logic dec_emit;
        act_t act;
        logic rep_last;
    } sts_t;

endpackage

// File: rtl/sct_if.sv
// valid/ready channel interfaces for input characters and result tokens
`timescale 1ns / 1ps

interface sct_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       terminator;

    modport source (output valid, output char_in, output terminator, input ready);
    modport sink (input valid, input char_in, input terminator, output ready);
endinterface

interface sct_out_if;
    logic       valid;
    logic       ready;
    logic [3:0] kind;
    logic [7:0] char_out;
    logic       literal;
    logic       word_has_literal;
    logic       last;

    modport source (
        output valid, output kind, output char_out, output literal,
        output word_has_literal, output last, input ready
    );
    modport sink (
        input valid, input kind, input char_out, input literal,
        input word_has_literal, input last, output ready
    );
endinterface

// File: rtl/sct_ctrl.sv
// sequencing controller of the tokenizer
`timescale 1ns / 1ps

module sct_ctrl
    import sct_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    input  sts_t sts,
    output cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISPATCH,
        S_REPLAY_W,
        S_REPLAY_IO,
        S_IOEND,
        S_FLUSH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ok_normal;

    // a plain push only needs the output when the hold stage is occupied
    assign ok_normal = !sts.hold_v || sts.out_free;
    assign in_ready  = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        cmd.src    = SRC_DECODE;
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                unique case (sts.act)
                    ACT_DONE:
                    begin
                        if (!sts.dec_emit)
                        begin
                            cmd.apply  = 1'b1;
                            state_next = sts.hold_v ? S_FLUSH : S_IDLE;
                        end
                        else if (!sts.hold_v)
                        begin
                            if (sts.out_free)
                            begin
                                cmd.apply      = 1'b1;
                                cmd.push_final = 1'b1;
                                state_next     = S_IDLE;
                            end
                        end
                        else if (sts.out_free)
                        begin
                            cmd.apply  = 1'b1;
                            cmd.push   = 1'b1;
                            state_next = S_FLUSH;
                        end
                    end
                    ACT_REDO:
                    begin
                        if (!sts.dec_emit || ok_normal)
                        begin
                            cmd.apply = 1'b1;
                            cmd.push  = sts.dec_emit;
                        end
                    end
                    ACT_REPLAY_WORD:
                    begin
                        cmd.apply  = 1'b1;
                        state_next = S_REPLAY_W;
                    end
                    ACT_REPLAY_IO:
                    begin
                        cmd.apply  = 1'b1;
                        state_next = S_REPLAY_IO;
                    end
                endcase
            end
            S_REPLAY_W:
            begin
                if (ok_normal)
                begin
                    cmd.push    = 1'b1;
                    cmd.src     = SRC_WDIGIT;
                    cmd.rep_adv = 1'b1;
                    if (sts.rep_last)
                    begin
                        state_next = S_DISPATCH;
                    end
                end
            end
            S_REPLAY_IO:
            begin
                if (ok_normal)
                begin
                    cmd.push    = 1'b1;
                    cmd.src     = SRC_IODIGIT;
                    cmd.rep_adv = 1'b1;
                    if (sts.rep_last)
                    begin
                        state_next = S_IOEND;
                    end
                end
            end
            S_IOEND:
            begin
                if (ok_normal)
                begin
                    cmd.push   = 1'b1;
                    cmd.src    = SRC_IOEND;
                    state_next = S_DISPATCH;
                end
            end
            S_FLUSH:
            begin
                if (sts.out_free)
                begin
                    cmd.flush  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/sct_datapath.sv
// lexer state, decoder, digit buffer and result registers
`timescale 1ns / 1ps

module sct_datapath
    import sct_pkg::*;
#(
    parameter int DIGIT_DEPTH = 16
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic [7:0] char_in,
    input  logic terminator,
    input  cmd_t cmd,
    output sts_t sts,
    sct_out_if.source out_ch
);

    localparam int CNT_W = $clog2(DIGIT_DEPTH + 1);
    localparam int IDX_W = (DIGIT_DEPTH > 1) ? $clog2(DIGIT_DEPTH) : 1;

    typedef enum logic [2:0] {
        PH_BETWEEN,
        PH_DIGITS,
        PH_WORD,
        PH_SINGLE,
        PH_DOUBLE,
        PH_ESCAPE,
        PH_GREATER,
        PH_DISCARD
    } phase_t;

    // captured transaction
    logic [7:0] char_reg;
    logic       term_reg;

    // lexer state
    phase_t             phase_reg, phase_next;
    logic               bnd_reg, bnd_next;
    logic               esc_reg, esc_next;
    logic               wls_reg, wls_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    // digit buffer and replay
    logic [3:0]         mem [DIGIT_DEPTH];
    logic [3:0]         rd_reg;
    logic [CNT_W-1:0]   rep_idx_reg, rep_idx_next;
    logic [IDX_W-1:0]   rd_addr;
    logic               rep_last;
    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;

    // hold and output stages
    res_t hold_reg;
    logic hold_v_reg;
    res_t out_res_reg;
    logic out_last_reg;
    logic out_v_reg;

    // decoder outputs
    logic d_emit;
    res_t d_res;
    act_t d_act;
    logic wc_take;
    logic wc_wls;

    logic c_space, c_op, c_digit;
    logic [7:0] c;
    res_t new_res;
    logic out_free;
    logic out_load;

    assign c       = char_reg;
    assign c_space = !term_reg && (c == C_SP || c == C_TAB || c == C_NL || c == C_VT
                     || c == C_FF || c == C_CR);
    assign c_op    = !term_reg && (c == C_PIPE || c == C_AMP || c == C_SEMI || c == C_LT
                     || c == C_GT);
    assign c_digit = !term_reg && (c >= C_ZERO) && (c <= C_NINE);

    always_comb
    begin
        d_emit     = 1'b0;
        d_res      = '0;
        d_act      = ACT_DONE;
        phase_next = phase_reg;
        bnd_next   = bnd_reg;
        esc_next   = esc_reg;
        wls_next   = wls_reg;
        count_next = count_reg;
        wr_en      = 1'b0;
        wr_addr    = '0;
        wc_take    = 1'b0;
        wc_wls     = wls_reg;
        unique case (phase_reg)
            PH_BETWEEN:
            begin
                priority if (term_reg)
                begin
                    d_emit     = 1'b1;
                    d_res      = '{K_END, 8'h00, 1'b0, 1'b0};
                    phase_next = PH_BETWEEN;
                    bnd_next   = 1'b1;
                    esc_next   = 1'b0;
                    wls_next   = 1'b0;
                    count_next = '0;
                end
                else if (c_space)
                begin
                    if (c == C_NL)
                    begin
                        d_emit     = 1'b1;
                        d_res      = '{K_END, 8'h00, 1'b0, 1'b0};
                        phase_next = PH_DISCARD;
                    end
                    else
                    begin
                        bnd_next = 1'b1;
                    end
                end
                else if (c == C_HASH && bnd_reg)
                begin
                    // comment at a token start ends the line
                    d_emit     = 1'b1;
                    d_res      = '{K_END, 8'h00, 1'b0, 1'b0};
                    phase_next = PH_DISCARD;
                end
                else if (c_digit)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = '0;
                    count_next = CNT_W'(1);
                    phase_next = PH_DIGITS;
                end
                else if (c == C_PIPE)
                begin
                    d_emit   = 1'b1;
                    d_res    = '{K_PIPE, 8'h00, 1'b0, 1'b0};
                    bnd_next = 1'b1;
                end
                else if (c == C_AMP)
                begin
                    d_emit   = 1'b1;
                    d_res    = '{K_BG, 8'h00, 1'b0, 1'b0};
                    bnd_next = 1'b1;
                end
                else if (c == C_SEMI)
                begin
                    d_emit   = 1'b1;
                    d_res    = '{K_SEMI, 8'h00, 1'b0, 1'b0};
                    bnd_next = 1'b1;
                end
                else if (c == C_LT)
                begin
                    d_emit   = 1'b1;
                    d_res    = '{K_RIN, 8'h00, 1'b0, 1'b0};
                    bnd_next = 1'b1;
                end
                else if (c == C_GT)
                begin
                    phase_next = PH_GREATER;
                end
                else
                begin
                    wc_take = 1'b1;
                    wc_wls  = 1'b0;
                end
            end
            PH_WORD:
            begin
                if (term_reg || c_space || c_op)
                begin
                    d_emit     = 1'b1;
                    d_res      = '{K_WEND, 8'h00, 1'b0, wls_reg};
                    wls_next   = 1'b0;
                    phase_next = PH_BETWEEN;
                    bnd_next   = 1'b0;
                    d_act      = ACT_REDO;
                end
                else
                begin
                    wc_take = 1'b1;
                    wc_wls  = wls_reg;
                end
            end
            PH_DIGITS:
            begin
                if (c_digit && (count_reg < CNT_W'(DIGIT_DEPTH)))
                begin
                    wr_en      = 1'b1;
                    wr_addr    = count_reg[IDX_W-1:0];
                    count_next = count_reg + CNT_W'(1);
                end
                else if (!term_reg && (c == C_LT || c == C_GT))
                begin
                    d_act      = ACT_REPLAY_IO;
                    phase_next = PH_BETWEEN;
                    bnd_next   = 1'b0;
                end
                else
                begin
                    // full buffer or any other character: the run is a word
                    d_act      = ACT_REPLAY_WORD;
                    phase_next = PH_WORD;
                    wls_next   = 1'b0;
                end
            end
            PH_SINGLE:
            begin
                priority if (term_reg)
                begin
                    d_emit     = 1'b1;
                    d_res      = '{K_ERR, 8'h00, 1'b0, 1'b0};
                    phase_next = PH_BETWEEN;
                    bnd_next   = 1'b1;
                    esc_next   = 1'b0;
                    wls_next   = 1'b0;
                    count_next = '0;
                end
                else if (c == C_SQ)
                begin
                    phase_next = PH_WORD;
                end
                else
                begin
                    d_emit   = 1'b1;
                    d_res    = '{K_WCHAR, c, 1'b1, 1'b0};
                    wls_next = 1'b1;
                end
            end
            PH_DOUBLE:
            begin
                priority if (term_reg)
                begin
                    d_emit     = 1'b1;
                    d_res      = '{K_ERR, 8'h00, 1'b0, 1'b0};
                    phase_next = PH_BETWEEN;
                    bnd_next   = 1'b1;
                    esc_next   = 1'b0;
                    wls_next   = 1'b0;
                    count_next = '0;
                end
                else if (c == C_DQ)
                begin
                    phase_next = PH_WORD;
                end
                else if (c == C_BS)
                begin
                    esc_next   = 1'b1;
                    phase_next = PH_ESCAPE;
                end
                else
                begin
                    d_emit = 1'b1;
                    d_res  = '{K_WCHAR, c, 1'b0, 1'b0};
                end
            end
            PH_ESCAPE:
            begin
                if (term_reg)
                begin
                    d_emit     = 1'b1;
                    d_res      = '{K_ERR, 8'h00, 1'b0, 1'b0};
                    phase_next = PH_BETWEEN;
                    bnd_next   = 1'b1;
                    esc_next   = 1'b0;
                    wls_next   = 1'b0;
                    count_next = '0;
                end
                else
                begin
                    phase_next = esc_reg ? PH_DOUBLE : PH_WORD;
                    esc_next   = 1'b0;
                    // backslash-newline is a line continuation
                    if (c != C_NL)
                    begin
                        d_emit   = 1'b1;
                        d_res    = '{K_WCHAR, c, 1'b1, 1'b0};
                        wls_next = 1'b1;
                    end
                end
            end
            PH_GREATER:
            begin
                phase_next = PH_BETWEEN;
                bnd_next   = 1'b1;
                d_emit     = 1'b1;
                if (!term_reg && c == C_GT)
                begin
                    d_res = '{K_RAPP, 8'h00, 1'b0, 1'b0};
                end
                else
                begin
                    d_res = '{K_ROUT, 8'h00, 1'b0, 1'b0};
                    d_act = ACT_REDO;
                end
            end
            PH_DISCARD:
            begin
                if (term_reg)
                begin
                    phase_next = PH_BETWEEN;
                    bnd_next   = 1'b1;
                    esc_next   = 1'b0;
                    wls_next   = 1'b0;
                    count_next = '0;
                end
            end
        endcase

        // ordinary word character, shared by a word start and a word body
        if (wc_take)
        begin
            phase_next = PH_WORD;
            wls_next   = wc_wls;
            priority if (c == C_SQ)
            begin
                phase_next = PH_SINGLE;
            end
            else if (c == C_DQ)
            begin
                phase_next = PH_DOUBLE;
            end
            else if (c == C_BS)
            begin
                esc_next   = 1'b0;
                phase_next = PH_ESCAPE;
            end
            else if (c == C_HASH)
            begin
                d_emit   = 1'b1;
                d_res    = '{K_WCHAR, c, 1'b1, 1'b0};
                wls_next = 1'b1;
            end
            else
            begin
                d_emit = 1'b1;
                d_res  = '{K_WCHAR, c, 1'b0, 1'b0};
            end
        end
    end

    // replay pointer; the read stage always shows the entry at the pointer
    assign rep_last = ((rep_idx_reg + CNT_W'(1)) == count_reg);

    always_comb
    begin
        rep_idx_next = rep_idx_reg;
        if (cmd.rep_adv)
        begin
            rep_idx_next = rep_last ? '0 : (rep_idx_reg + CNT_W'(1));
        end
    end

    assign rd_addr = rep_idx_next[IDX_W-1:0];

    always_comb
    begin
        unique case (cmd.src)
            SRC_DECODE:  new_res = d_res;
            SRC_WDIGIT:  new_res = '{K_WCHAR, {DIGIT_HI, rd_reg}, 1'b0, 1'b0};
            SRC_IODIGIT: new_res = '{K_IODIG, {DIGIT_HI, rd_reg}, 1'b0, 1'b0};
            SRC_IOEND:   new_res = '{K_IOEND, 8'h00, 1'b0, 1'b0};
            default:     new_res = d_res;
        endcase
    end

    assign out_free = !out_v_reg || out_ch.ready;
    assign out_load = cmd.push_final || cmd.flush || (cmd.push && hold_v_reg);

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= c[3:0];
        end
        rd_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            char_reg <= char_in;
            term_reg <= terminator;
        end
        if (cmd.push)
        begin
            hold_reg <= new_res;
        end
        if (cmd.push_final)
        begin
            out_res_reg  <= new_res;
            out_last_reg <= 1'b1;
        end
        else if (out_load)
        begin
            out_res_reg  <= hold_reg;
            out_last_reg <= cmd.flush;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= PH_BETWEEN;
            bnd_reg     <= 1'b1;
            esc_reg     <= 1'b0;
            wls_reg     <= 1'b0;
            count_reg   <= '0;
            rep_idx_reg <= '0;
            hold_v_reg  <= 1'b0;
            out_v_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.apply)
            begin
                phase_reg <= phase_next;
                bnd_reg   <= bnd_next;
                esc_reg   <= esc_next;
                wls_reg   <= wls_next;
                count_reg <= count_next;
            end
            else if (cmd.rep_adv && rep_last)
            begin
                count_reg <= '0;
            end
            rep_idx_reg <= rep_idx_next;
            if (cmd.push)
            begin
                hold_v_reg <= 1'b1;
            end
            else if (cmd.flush)
            begin
                hold_v_reg <= 1'b0;
            end
            if (out_load)
            begin
                out_v_reg <= 1'b1;
            end
            else if (out_ch.ready)
            begin
                out_v_reg <= 1'b0;
            end
        end
    end

    assign sts.hold_v   = hold_v_reg;
    assign sts.out_free = out_free;
    assign sts.dec_emit = d_emit;
    assign sts.act      = d_act;
    assign sts.rep_last = rep_last;

    assign out_ch.valid            = out_v_reg;
    assign out_ch.kind             = out_res_reg.kind;
    assign out_ch.char_out         = out_res_reg.ch;
    assign out_ch.literal          = out_res_reg.lit;
    assign out_ch.word_has_literal = out_res_reg.hl;
    assign out_ch.last             = out_last_reg;

endmodule

// File: rtl/shell_command_tokenizer.sv
// top level of the shell command tokenizer
// usage:
//   in_ch carries one command-line byte per transaction (char_in), or a
//   transaction with terminator set that closes the input string
//   out_ch carries the tokens: word characters with their literal mark, word
//   ends with the has-literal flag, io digits and io end, operators, end of
//   line and parse error; last marks the final result of the input transaction
// sequencing:
//   an input byte is decoded in the cycle after its transaction; a lone result
//   goes straight to the output register when the hold stage is empty, else
//   each result passes through the hold stage, and the final result is
//   released from the hold stage by a flush
//   a buffered digit run (up to DIGIT_DEPTH digits) is replayed one digit per
//   cycle unless a full hold stage waits on the output; io digits get an io end
// reset:
//   rst_n clears the lexer to "between tokens" and empties both stages; only
//   digit entries written in the current run are ever read
// stalls:
//   a new transaction is taken while a finished result waits in the output
//   register; results stop in the hold stage until the output register is free
`timescale 1ns / 1ps

module shell_command_tokenizer
    import sct_pkg::*;
#(
    parameter int DIGIT_DEPTH = 16
)
(
    input  logic clk,
    input  logic rst_n,
    sct_in_if.sink    in_ch,
    sct_out_if.source out_ch
);

    cmd_t cmd;
    sts_t sts;

    // sequencer: accepts a transaction, steps the decoder, drives replay
    sct_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_ready (in_ch.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // lexer state, digit buffer, hold stage and output register
    sct_datapath #(
        .DIGIT_DEPTH (DIGIT_DEPTH)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_in    (in_ch.char_in),
        .terminator (in_ch.terminator),
        .cmd        (cmd),
        .sts        (sts),
        .out_ch     (out_ch)
    );

endmodule
